// ===== sv/el1ex_pkg.sv =====
// Shared types, codes and helpers for the EL0/EL1 exception entry/return block.
// No dependencies; every module of the block imports this package.
package el1ex_pkg;

  // Command codes
  localparam logic CMD_TAKE   = 1'b0;
  localparam logic CMD_RETURN = 1'b1;

  // SPSR M[4:0] encodings
  localparam logic [4:0] MODE_EL0T = 5'b00000;
  localparam logic [4:0] MODE_EL1T = 5'b00100;
  localparam logic [4:0] MODE_EL1H = 5'b00101;

  // Vector table offsets
  localparam logic [63:0] OFF_CUR_SP0 = 64'h000;
  localparam logic [63:0] OFF_CUR_SPX = 64'h200;
  localparam logic [63:0] OFF_LOWER   = 64'h400;

  // All DAIF bits set on entry
  localparam logic [3:0] DAIF_ALL = 4'hF;

  // Exception classes that capture a fault address
  localparam logic [5:0] EC_IABT_LOW  = 6'h20;
  localparam logic [5:0] EC_IABT_CUR  = 6'h21;
  localparam logic [5:0] EC_PC_ALIGN  = 6'h22;
  localparam logic [5:0] EC_DABT_LOW  = 6'h24;
  localparam logic [5:0] EC_DABT_CUR  = 6'h25;
  localparam logic [5:0] EC_SP_ALIGN  = 6'h26;

  // One command beat
  typedef struct packed {
    logic        command;
    logic [5:0]  exception_class;
    logic [24:0] syndrome;
    logic [63:0] fault_address;
    logic [63:0] return_address;
    logic [63:0] saved_status;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic        accepted;
    logic [63:0] program_counter;
    logic        exception_level;
    logic        stack_select;
    logic [3:0]  condition_flags;
    logic [3:0]  interrupt_masks;
    logic [63:0] status_saved;
    logic [63:0] link_saved;
    logic [31:0] syndrome_saved;
    logic [63:0] fault_saved;
  } out_item_t;

  // True for the abort and alignment classes
  function automatic logic class_has_address(input logic [5:0] ec);
    return (ec == EC_IABT_LOW) || (ec == EC_IABT_CUR) || (ec == EC_PC_ALIGN) ||
           (ec == EC_DABT_LOW) || (ec == EC_DABT_CUR) || (ec == EC_SP_ALIGN);
  endfunction

endpackage

// ===== sv/el1_exception_entry_return.sv =====
// EL0/EL1 exception entry and return unit. Each command beat (take an
// exception or return with a given SPSR) updates the processor state held
// here and yields one result beat with the state after the command. A command
// passes an input register and then a result register before its result is
// offered, and one command is taken every cycle while out_stall does not hold
// the result register: the state feedback through the core logic is combinational.
// cfg_ready is always high; write vector_base only while no command is
// in flight. Depends on el1ex_pkg, el1ex_in_stage, el1ex_core, el1ex_out_stage.
module el1_exception_entry_return
  import el1ex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  logic      advance;
  logic      hold_valid;
  in_item_t  hold_item;
  out_item_t result;
  logic      fire;

  // Config writes land at once
  assign cfg_ready = 1'b1;
  // Command moves into the core when the result register has room
  assign fire      = hold_valid && advance;

  el1ex_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  el1ex_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .cmd       (hold_item),
    .result    (result)
  );

  el1ex_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== sv/el1ex_in_stage.sv =====
// Input register of the exception block: captures one command beat.
// Depends on el1ex_pkg for the command struct.
module el1ex_in_stage
  import el1ex_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     hold_valid,
  output in_item_t hold_item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     load;

  // Stall only when a held beat cannot move on this cycle
  assign in_stall   = valid_r && !advance;
  assign load       = in_valid && !in_stall;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  // Refill on a new beat, drop when the held beat moves on
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== sv/el1ex_core.sv =====
// Processor state and the take/return logic of the exception block.
// Depends on el1ex_pkg for types, mode codes, offsets and class decode.
module el1ex_core
  import el1ex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic [63:0] cfg_data,
  input  logic        fire,
  input  in_item_t    cmd,
  output out_item_t   result
);

  logic        vbar_r;
  logic [63:0] vector_base_r;
  logic        level_r, level_nxt;
  logic        sel_r, sel_nxt;
  logic [3:0]  flags_r, flags_nxt;
  logic [3:0]  masks_r, masks_nxt;
  logic [63:0] pc_r, pc_nxt;
  logic [63:0] spsr_r, spsr_nxt;
  logic [63:0] elr_r, elr_nxt;
  logic [31:0] esr_r, esr_nxt;
  logic [63:0] far_r, far_nxt;
  logic        ok;
  logic [4:0]  cur_mode;
  logic [63:0] offset;
  logic        ret_el;
  logic        ret_sel;
  logic        ret_mode_ok;

  // Mode and vector offset of the current state
  always_comb begin
    if (!level_r) begin
      cur_mode = MODE_EL0T;
      offset   = OFF_LOWER;
    end else if (sel_r) begin
      cur_mode = MODE_EL1H;
      offset   = OFF_CUR_SPX;
    end else begin
      cur_mode = MODE_EL1T;
      offset   = OFF_CUR_SP0;
    end
  end

  // Decode the target mode of a return; AArch32 and EL2/EL3 fall to default
  always_comb begin
    ret_el      = 1'b0;
    ret_sel     = 1'b0;
    ret_mode_ok = 1'b1;
    case (cmd.saved_status[4:0])
      MODE_EL0T: begin
        ret_el  = 1'b0;
        ret_sel = 1'b0;
      end
      MODE_EL1T: begin
        ret_el  = 1'b1;
        ret_sel = 1'b0;
      end
      MODE_EL1H: begin
        ret_el  = 1'b1;
        ret_sel = 1'b1;
      end
      default: begin
        ret_mode_ok = 1'b0;
      end
    endcase
  end

  // Next architectural state for the command in hand
  always_comb begin
    level_nxt = level_r;
    sel_nxt   = sel_r;
    flags_nxt = flags_r;
    masks_nxt = masks_r;
    pc_nxt    = pc_r;
    spsr_nxt  = spsr_r;
    elr_nxt   = elr_r;
    esr_nxt   = esr_r;
    far_nxt   = far_r;
    ok        = 1'b1;
    if (cmd.command == CMD_TAKE) begin
      spsr_nxt  = {32'h0, flags_r, 18'h0, masks_r, 1'b0, cur_mode};
      elr_nxt   = cmd.return_address;
      esr_nxt   = {cmd.exception_class, 1'b1, cmd.syndrome};
      if (class_has_address(cmd.exception_class)) begin
        far_nxt = cmd.fault_address;
      end
      level_nxt = 1'b1;
      sel_nxt   = 1'b1;
      masks_nxt = DAIF_ALL;
      pc_nxt    = vector_base_r + offset;
    end else begin
      // Reject unknown modes and a return to a higher level
      ok = ret_mode_ok && !(ret_el && !level_r);
      if (ok) begin
        flags_nxt = cmd.saved_status[31:28];
        masks_nxt = cmd.saved_status[9:6];
        level_nxt = ret_el;
        sel_nxt   = ret_sel;
      end
    end
  end

  // Result shows the state after the command
  always_comb begin
    result.accepted        = ok;
    result.program_counter = pc_nxt;
    result.exception_level = level_nxt;
    result.stack_select    = sel_nxt;
    result.condition_flags = flags_nxt;
    result.interrupt_masks = masks_nxt;
    result.status_saved    = spsr_nxt;
    result.link_saved      = elr_nxt;
    result.syndrome_saved  = esr_nxt;
    result.fault_saved     = far_nxt;
  end

  // Hold state; advance on each command beat, take vector base writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vbar_r        <= 1'b0;
      vector_base_r <= 64'h0;
      level_r       <= 1'b0;
      sel_r         <= 1'b0;
      flags_r       <= 4'h0;
      masks_r       <= 4'h0;
      pc_r          <= 64'h0;
      spsr_r        <= 64'h0;
      elr_r         <= 64'h0;
      esr_r         <= 32'h0;
      far_r         <= 64'h0;
    end else begin
      vbar_r <= cfg_valid;
      if (cfg_valid) begin
        vector_base_r <= cfg_data;
      end
      if (fire) begin
        level_r <= level_nxt;
        sel_r   <= sel_nxt;
        flags_r <= flags_nxt;
        masks_r <= masks_nxt;
        pc_r    <= pc_nxt;
        spsr_r  <= spsr_nxt;
        elr_r   <= elr_nxt;
        esr_r   <= esr_nxt;
        far_r   <= far_nxt;
      end
    end
  end

  // A taken exception always lands in EL1h with DAIF masked
  a_take_enters_el1h: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (cmd.command == CMD_TAKE) |=> level_r && sel_r && (masks_r == DAIF_ALL))
    else $error("take did not enter EL1h with DAIF masked");

  // A rejected return leaves the processor state alone
  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !ok |=> $stable(level_r) && $stable(sel_r) && $stable(flags_r) &&
                    $stable(masks_r) && $stable(pc_r))
    else $error("rejected return changed state");

  // ESR always carries IL=1 after a take
  a_esr_il: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (cmd.command == CMD_TAKE) |=> esr_r[25])
    else $error("ESR IL bit clear after take");

  // Returns never move the PC
  a_return_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (cmd.command == CMD_RETURN) |=> $stable(pc_r))
    else $error("exception return changed the PC");

  // Vector base write marker tracks the config channel
  a_cfg_seen: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |=> vbar_r && (vector_base_r == $past(cfg_data)))
    else $error("vector base write lost");

endmodule

// ===== sv/el1ex_out_stage.sv =====
// Result register of the exception block: holds one result beat under stall.
// Depends on el1ex_pkg for the result struct.
module el1ex_out_stage
  import el1ex_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  out_item_t result,
  output logic      advance,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      valid_r;
  out_item_t item_r;

  // Register is free when empty or being drained this cycle
  assign advance   = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= fire;
    end
  end

  // Capture a new result beat
  always_ff @(posedge clk) begin
    if (fire) begin
      item_r <= result;
    end
  end

endmodule
